// ----- rtl/rgb_error_diffusion_halftone_top_defines.svh -----
// Assertion macros shared by the halftone block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef RGB_ERROR_DIFFUSION_HALFTONE_TOP_DEFINES_SVH
`define RGB_ERROR_DIFFUSION_HALFTONE_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define RGBHT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rgbht assertion failed");

// Check that a trigger is followed in the next cycle by a consequence.
`define RGBHT_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("rgbht assertion failed");

`endif

// ----- rtl/rgbht_pkg.sv -----
package rgbht_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int FILL_W      = $clog2(MAX_WIDTH + 1);
    localparam int WIDTH_W     = 11;
    localparam int THR_W       = 8;
    localparam int PIX_W       = 8;
    localparam int ERR_W       = 10;
    localparam int NUM_CH      = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;

    typedef logic [COL_W-1:0] col_t;
    typedef logic [NUM_CH-1:0][ERR_W-1:0] err3_t;

    // Classified pixel as it travels from front to back; channel 0 is red.
    typedef struct packed {
        logic                         clear;
        logic                         last;
        col_t                         col;
        logic [NUM_CH-1:0][PIX_W-1:0] px;
    } pix_t;

    typedef struct packed {
        logic row_end;
        logic blue;
        logic green;
        logic red;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- rtl/rgbht_front.sv -----
module rgbht_front
    import rgbht_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [NUM_CH*PIX_W-1:0]   s_tdata,
    input  logic                      s_tuser,
    input  logic [WIDTH_W-1:0]        image_width,
    input  q_stat_t                   stat,
    output logic                      push,
    output pix_t                      item
);

    col_t              col_count_reg;
    col_t              col_count_next;
    logic [FILL_W-1:0] w_eff;
    col_t              last_col;
    col_t              col_raw;

    assign s_tready = !stat.full;
    assign push     = s_tvalid && !stat.full;

    always_comb
    begin
        // Clamp the width into 1..MAX_WIDTH.
        priority if (image_width == '0)
        begin
            w_eff = FILL_W'(1);
        end
        else if (32'(image_width) > MAX_WIDTH)
        begin
            w_eff = FILL_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = FILL_W'(image_width);
        end
        last_col = COL_W'(w_eff - FILL_W'(1));

        col_raw = s_tuser ? '0 : col_count_reg;

        item.clear = s_tuser;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            item.px[ch] = s_tdata[ch*PIX_W +: PIX_W];
        end
        if (col_raw >= last_col)
        begin
            item.col = last_col;
            item.last = 1'b1;
        end
        else
        begin
            item.col = col_raw;
            item.last = 1'b0;
        end

        col_count_next = item.last ? '0 : item.col + COL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
        end
        else if (push)
        begin
            col_count_reg <= col_count_next;
        end
    end

endmodule

// ----- rtl/rgbht_queue.sv -----
module rgbht_queue
    import rgbht_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  pix_t    push_item,
    input  logic    pop,
    output pix_t    head,
    output q_stat_t stat
);

    pix_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (32'(p) == QUEUE_DEPTH - 1)
        begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (32'(count_reg) == QUEUE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- rtl/rgbht_back.sv -----
module rgbht_back
    import rgbht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  q_stat_t          stat,
    input  pix_t             head,
    output logic             pop,
    input  logic [THR_W-1:0] threshold,
    output logic             m_tvalid,
    input  logic             m_tready,
    output res_t             res
);

    localparam int SUM_W  = ERR_W + 1;
    localparam int PROD_W = ERR_W + 2;

    // Error line store: one word of three channel errors per column.
    err3_t mem [MAX_WIDTH];

    logic              s1_valid_reg;
    pix_t              s1_item_reg;
    err3_t             rd0_reg;
    err3_t             rd1_reg;
    err3_t             right_reg;
    err3_t             right_next;
    err3_t             diag_reg;
    err3_t             diag_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    col_t              pend_idx_reg;
    col_t              pend_idx_next;
    err3_t             pend_val_reg;
    err3_t             pend_val_next;
    logic              wb_valid_reg;
    logic              wb_valid_next;
    col_t              wb_addr_reg;
    err3_t             wb_data_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              out_valid_reg;
    res_t              out_data_reg;
    res_t              out_data_next;

    logic              s1_fire;
    logic              wr_en;
    col_t              wr_addr;
    err3_t             wr_data;
    col_t              col;
    col_t              colm1;
    err3_t             ec;
    err3_t             ecm1;
    err3_t             rin;
    err3_t             din;
    err3_t             s5_vec;
    err3_t             s3_vec;
    logic [NUM_CH-1:0] qbit;
    logic [FILL_W-1:0] wr_top;

    function automatic err3_t fetch(
        input col_t              addr,
        input logic              pv,
        input col_t              pi,
        input err3_t             pval,
        input logic              wv,
        input col_t              wa,
        input err3_t             wd,
        input logic [FILL_W-1:0] fill,
        input err3_t             md
    );
        priority if (pv && pi == addr)
        begin
            return pval;
        end
        else if (wv && wa == addr)
        begin
            return wd;
        end
        else if (FILL_W'(addr) < fill)
        begin
            return md;
        end
        else
        begin
            return '0;
        end
    endfunction

    function automatic logic [PIX_W-1:0] clamp_px(input logic signed [SUM_W-1:0] x);
        priority if (x < 0)
        begin
            return '0;
        end
        else if (x > SUM_W'(255))
        begin
            return 8'd255;
        end
        else
        begin
            return x[PIX_W-1:0];
        end
    endfunction

    // Divide by sixteen, truncating toward zero.
    function automatic logic [ERR_W-1:0] div16(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] mag;
        logic signed [PROD_W-1:0] q;
        mag = x[PROD_W-1] ? -x : x;
        q = mag >>> 4;
        if (x[PROD_W-1])
        begin
            q = -q;
        end
        return q[ERR_W-1:0];
    endfunction

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign pop      = !stat.empty && (!s1_valid_reg || s1_fire);
    assign m_tvalid = out_valid_reg;
    assign res      = out_data_reg;
    assign col      = s1_item_reg.col;
    assign colm1    = s1_item_reg.col - COL_W'(1);

    always_comb
    begin
        logic [PIX_W-1:0]          v;
        logic signed [SUM_W-1:0]   sum;
        logic [ERR_W-1:0]          e;
        logic signed [PROD_W-1:0]  ex;
        logic signed [PROD_W-1:0]  p7;
        logic signed [PROD_W-1:0]  p5;
        logic signed [PROD_W-1:0]  p3;

        ec   = fetch(col, pend_valid_reg, pend_idx_reg, pend_val_reg,
                     wb_valid_reg, wb_addr_reg, wb_data_reg, fill_reg, rd0_reg);
        ecm1 = fetch(colm1, pend_valid_reg, pend_idx_reg, pend_val_reg,
                     wb_valid_reg, wb_addr_reg, wb_data_reg, fill_reg, rd1_reg);
        rin  = right_reg;
        din  = diag_reg;
        if (s1_item_reg.clear)
        begin
            ec  = '0;
            rin = '0;
            din = '0;
        end

        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            sum = $signed({3'b000, s1_item_reg.px[ch]})
                + $signed({ec[ch][ERR_W-1], ec[ch]})
                + $signed({rin[ch][ERR_W-1], rin[ch]});
            v = clamp_px(sum);
            qbit[ch] = (v >= threshold);
            e = qbit[ch] ? ({2'b00, v} - ERR_W'(255)) : {2'b00, v};
            ex = $signed({{2{e[ERR_W-1]}}, e});
            p7 = ex * PROD_W'(7);
            p5 = ex * PROD_W'(5);
            p3 = ex * PROD_W'(3);
            s5_vec[ch]     = din[ch] + div16(p5);
            s3_vec[ch]     = ecm1[ch] + div16(p3);
            right_next[ch] = s1_item_reg.last ? '0 : div16(p7);
            diag_next[ch]  = s1_item_reg.last ? '0 : div16(ex);
        end

        out_data_next.red     = qbit[0];
        out_data_next.green   = qbit[1];
        out_data_next.blue    = qbit[2];
        out_data_next.row_end = s1_item_reg.last;
    end

    // Line store write, pending entry and fill mark.
    always_comb
    begin
        wr_en           = 1'b0;
        wr_addr         = pend_idx_reg;
        wr_data         = pend_val_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_val_next   = pend_val_reg;
        wb_valid_next   = wb_valid_reg;
        fill_next       = fill_reg;

        if (s1_fire)
        begin
            pend_valid_next = 1'b1;
            pend_idx_next   = col;
            pend_val_next   = s5_vec;
            priority if (s1_item_reg.clear)
            begin
                // Drop everything owed to the old frame.
                wb_valid_next = 1'b0;
                fill_next     = '0;
            end
            else if (col != '0)
            begin
                wr_en   = 1'b1;
                wr_addr = colm1;
                wr_data = s3_vec;
            end
            else if (pend_valid_reg && pend_idx_reg != '0)
            begin
                wr_en = 1'b1;
            end
            else
            begin
                // Column zero consumed the pending entry; nothing to write.
                wr_en = 1'b0;
            end
        end
        else if (pend_valid_reg && !s1_valid_reg)
        begin
            // Retire the pending entry while the compute stage is empty; a
            // waiting pixel keeps it, so the last write stays forwardable.
            wr_en           = 1'b1;
            pend_valid_next = 1'b0;
        end

        wr_top = FILL_W'(wr_addr) + FILL_W'(1);
        if (wr_en)
        begin
            wb_valid_next = 1'b1;
            if (wr_top > fill_reg)
            begin
                fill_next = wr_top;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (pop)
        begin
            rd0_reg <= mem[head.col];
            rd1_reg <= mem[head.col - COL_W'(1)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_item_reg <= head;
        end
        if (s1_fire)
        begin
            out_data_reg <= out_data_next;
            pend_idx_reg <= pend_idx_next;
            pend_val_reg <= pend_val_next;
        end
        if (wr_en)
        begin
            wb_addr_reg <= wr_addr;
            wb_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            right_reg      <= '0;
            diag_reg       <= '0;
            pend_valid_reg <= 1'b0;
            wb_valid_reg   <= 1'b0;
            fill_reg       <= '0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                right_reg     <= right_next;
                diag_reg      <= diag_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            pend_valid_reg <= pend_valid_next;
            wb_valid_reg   <= wb_valid_next;
            fill_reg       <= fill_next;
        end
    end

endmodule

// ----- rtl/rgb_error_diffusion_halftone_top.sv -----
// Channel   Dir  Handshake            Payload
// s_axis    in   s_tvalid/s_tready    s_tdata: red, green, blue; s_tuser: frame_start
// m_axis    out  m_tvalid/m_tready    m_tdata: red, green, blue bits; m_tlast: row_end
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel per clock sustained while the output does not stall; the compute stage
// closes the right-error loop, and the line store gives one write and two reads
// per cycle. Each pixel is registered in the queue, the compute stage and the output.
// Reset needs no clearing pass: a fill mark says which line-store columns were
// written since the last frame start, so all others read as zero.
// A four-entry queue between classifier and compute absorbs output stalls.
`include "rgb_error_diffusion_halftone_top_defines.svh"

module rgb_error_diffusion_halftone_top
    import rgbht_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Fields from bit 0: red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [NUM_CH*PIX_W-1:0] s_tdata,
    // Fields from bit 0: frame_start
    input  logic                    s_tuser,
    // Fields from bit 0: red_out, green_out, blue_out, zero fill
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,
    output logic                    m_tlast,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [WIDTH_W-1:0]      cfg_data
);

    logic [WIDTH_W-1:0] image_width_reg;
    logic [THR_W-1:0]   threshold_reg;

    logic    q_push;
    logic    q_pop;
    pix_t    q_in;
    pix_t    q_head;
    q_stat_t q_stat;
    res_t    res;

    // Register writes are never stalled; cfg_ready is tied high.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= WIDTH_W'(256);
            threshold_reg   <= THR_W'(128);
        end
        else if (cfg_valid)
        begin
            // Ignore indexes beyond the register list.
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: image_width_reg <= cfg_data;
                CFG_THRESHOLD:   threshold_reg   <= cfg_data[THR_W-1:0];
                default:         image_width_reg <= image_width_reg;
            endcase
        end
    end

    // Front: accept the pixel, track the column and flag row end.
    rgbht_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .image_width (image_width_reg),
        .stat        (q_stat),
        .push        (q_push),
        .item        (q_in)
    );

    // Hold classified pixels until the compute stage takes them.
    rgbht_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // Back: fetch line errors, quantize, diffuse and present the result.
    rgbht_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (q_stat),
        .head      (q_head),
        .pop       (q_pop),
        .threshold (threshold_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .res       (res)
    );

    assign m_tdata = {5'b00000, res.blue, res.green, res.red};
    assign m_tlast = res.row_end;

    // A frame start always lands in column zero.
    `RGBHT_ASSERT(a_clear_col0, q_push && q_in.clear |-> q_in.col == '0)
    // The widest possible column always ends its row.
    `RGBHT_ASSERT(a_max_col_last, q_push && q_in.col == COL_W'(MAX_WIDTH - 1) |-> q_in.last)
    // A new result must come from a pixel that was waiting in the queue.
    `RGBHT_ASSERT(a_out_from_queue, $rose(m_tvalid) |-> $past(!q_stat.empty, 2))
    // A full queue with no pop keeps the input stalled.
    `RGBHT_ASSERT_NEXT(a_full_stalls, q_stat.full && !q_pop, !s_tready)

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    import rgbht_pkg::*;

    // Indexes that decode to no register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Cycles to hold after the last result before touching the registers.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 570;

    typedef enum int
    {
        CONTENT_UNIFORM,
        CONTENT_EXTREME,
        CONTENT_FLAT,
        CONTENT_NEAR_THRESHOLD
    } content_t;

    typedef logic [NUM_CH-1:0][PIX_W-1:0] rgb_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [NUM_CH*PIX_W-1:0] s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [7:0]              m_tdata;
    logic                    m_tlast;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [WIDTH_W-1:0]      cfg_data;

    // Shadow copy of the halftoner: registers, error line, carries, column.
    logic [WIDTH_W-1:0] width_setting;
    logic [THR_W-1:0]   threshold_setting;
    int                 below_err [MAX_WIDTH][NUM_CH];
    int                 right_err [NUM_CH];
    int                 diag_err [NUM_CH];
    int                 next_col;

    // Halftoned pixels still owed by the block, oldest first.
    res_t halftone_q[$];

    int  error_count;
    int  pixels_sent;
    int  rows_predicted;
    int  results_checked;
    int  reg_writes;
    bit  tx_steady;
    bit  rx_steady;

    always #5 clk = ~clk;

    rgb_error_diffusion_halftone_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_diffusion();
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                below_err[c][ch] = 0;
            end
        end
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            right_err[ch] = 0;
            diag_err[ch]  = 0;
        end
        next_col = 0;
    endfunction

    // Halftone one pixel and spread its error: 7/16 right, 3/16 below-left,
    // 5/16 below, 1/16 below-right, every share truncated toward zero.
    function automatic res_t halftone_pixel(input rgb_t px, input logic frame_start);
        int                w;
        int                col;
        bit                last;
        int                v;
        int                q;
        int                e;
        logic [NUM_CH-1:0] bits;
        res_t              res;
        w = int'(width_setting);
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (frame_start)
            clear_diffusion();
        col  = next_col;
        // A column at or past the edge (width shrunk mid-row) ends the row.
        last = (col >= w - 1);
        if (last)
            col = w - 1;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            v = int'(px[ch]) + below_err[col][ch] + right_err[ch];
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            q        = (v >= int'(threshold_setting)) ? 255 : 0;
            bits[ch] = (q != 0);
            e        = v - q;
            if (col > 0)
                below_err[col - 1][ch] = below_err[col - 1][ch] + (e * 3) / 16;
            below_err[col][ch] = diag_err[ch] + (e * 5) / 16;
            if (last)
            begin
                right_err[ch] = 0;
                diag_err[ch]  = 0;
            end
            else
            begin
                right_err[ch] = (e * 7) / 16;
                diag_err[ch]  = e / 16;
            end
        end
        next_col = last ? 0 : col + 1;
        if (last)
            rows_predicted++;
        res.red     = bits[0];
        res.green   = bits[1];
        res.blue    = bits[2];
        res.row_end = last;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic rgb_t make_rgb(input int red, input int green, input int blue);
        rgb_t px;
        px[0] = red[PIX_W-1:0];
        px[1] = green[PIX_W-1:0];
        px[2] = blue[PIX_W-1:0];
        return px;
    endfunction

    function automatic int clamp_sample(input int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    function automatic int pick_sample(input content_t mode, input int base);
        int r;
        case (mode)
            CONTENT_EXTREME:
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    return 1;
                if (r == 1)
                    return 254;
                return (r < 6) ? 0 : 255;
            end
            CONTENT_FLAT:
                return clamp_sample(base + int'($urandom_range(0, 8)) - 4);
            CONTENT_NEAR_THRESHOLD:
                return clamp_sample(int'(threshold_setting) + int'($urandom_range(0, 6)) - 3);
            default:
                return $urandom_range(0, 255);
        endcase
    endfunction

    // Send one pixel; return at the edge that accepted it with tvalid still
    // high, so a following pixel can go out back to back.
    task automatic send_pixel(input rgb_t px, input logic frame_start);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= frame_start;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        halftone_q.push_back(halftone_pixel(px, frame_start));
        pixels_sent++;
    endtask

    // Drop tvalid and hold until every owed result has arrived, then let the
    // pipeline run empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (halftone_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH: width_setting = data;
            CFG_THRESHOLD:   threshold_setting = data[THR_W-1:0];
            default:         ;
        endcase
        reg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Compare every transaction on the output against the oldest prediction.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (halftone_q.size() == 0)
            begin
                $error("result with no pixel outstanding: tdata %0h tlast %0b",
                       m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                want = halftone_q.pop_front();
                check_field("red_out", {7'd0, want.red}, {7'd0, m_tdata[0]});
                check_field("green_out", {7'd0, want.green}, {7'd0, m_tdata[1]});
                check_field("blue_out", {7'd0, want.blue}, {7'd0, m_tdata[2]});
                check_field("fill", 8'h00, {3'b000, m_tdata[7:3]});
                check_field("row_end", {7'd0, want.row_end}, {7'd0, m_tlast});
                results_checked++;
            end
        end
    end

    // Output backpressure: ready bursts separated by random stalls; rx_steady
    // holds ready high for whole phases.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pick_gap(rx_steady);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values (width 256, threshold 128) and a start with no frame mark.
    task automatic test_reset_defaults();
        send_pixel(make_rgb(0, 255, 128), 1'b0);
        send_pixel(make_rgb(127, 128, 255), 1'b1);
        send_pixel(make_rgb(255, 0, 127), 1'b0);
    endtask

    // Row ends, first column, width 0, width shrunk in the middle of a row.
    task automatic test_row_geometry();
        // Width 0 behaves as 1: every pixel ends its row.
        write_reg(CFG_IMAGE_WIDTH, 11'd0);
        send_pixel(make_rgb(255, 0, 128), 1'b1);
        send_pixel(make_rgb(0, 255, 127), 1'b0);
        send_pixel(make_rgb(128, 128, 128), 1'b0);

        // Two full rows of three: below-left dropped at column 0,
        // right and below-right dropped at the row end.
        write_reg(CFG_IMAGE_WIDTH, 11'd3);
        send_pixel(make_rgb(200, 60, 127), 1'b1);
        send_pixel(make_rgb(255, 0, 90), 1'b0);
        send_pixel(make_rgb(0, 255, 170), 1'b0);
        send_pixel(make_rgb(100, 130, 255), 1'b0);
        send_pixel(make_rgb(30, 220, 0), 1'b0);
        send_pixel(make_rgb(140, 110, 64), 1'b0);

        // Shrink the width once the row is past the new edge.
        write_reg(CFG_IMAGE_WIDTH, 11'd5);
        send_pixel(make_rgb(90, 160, 200), 1'b1);
        send_pixel(make_rgb(10, 250, 128), 1'b0);
        send_pixel(make_rgb(250, 5, 129), 1'b0);
        write_reg(CFG_IMAGE_WIDTH, 11'd2);
        send_pixel(make_rgb(120, 120, 120), 1'b0);
        send_pixel(make_rgb(60, 190, 33), 1'b0);
    endtask

    // Threshold at both ends; the frame carries on without a new frame mark.
    task automatic test_threshold_extremes();
        // Upper data bits above the threshold field are ignored.
        write_reg(CFG_THRESHOLD, {3'b101, 8'd0});
        send_pixel(make_rgb(0, 1, 255), 1'b0);
        send_pixel(make_rgb(0, 0, 0), 1'b0);
        write_reg(CFG_THRESHOLD, 11'd255);
        send_pixel(make_rgb(254, 255, 255), 1'b0);
        send_pixel(make_rgb(255, 255, 1), 1'b0);
    endtask

    // Unused register indexes must not disturb width or threshold.
    task automatic test_spare_indexes();
        write_reg(CFG_SPARE_2, 11'h7FF);
        write_reg(CFG_SPARE_3, 11'h000);
        send_pixel(make_rgb(128, 254, 255), 1'b1);
        send_pixel(make_rgb(255, 127, 0), 1'b0);
    endtask

    // One row across the whole line store: start at width 1024, then switch
    // to 2047 (clamped to 1024) mid-row and run to the last column.
    task automatic test_widest_row();
        rgb_t px;
        write_reg(CFG_THRESHOLD, 11'd128);
        write_reg(CFG_IMAGE_WIDTH, 11'd1024);
        for (int i = 0; i < 5; i++)
        begin
            px = make_rgb($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            send_pixel(px, i == 0);
        end
        write_reg(CFG_IMAGE_WIDTH, 11'd2047);
        for (int i = 5; i < MAX_WIDTH; i++)
        begin
            px = make_rgb($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            send_pixel(px, 1'b0);
        end
    endtask

    // Back-to-back burst, then hold the sender until every result is in,
    // then resume the same frame.
    task automatic test_sender_pause();
        rgb_t px;
        write_reg(CFG_IMAGE_WIDTH, 11'd7);
        tx_steady = 1'b1;
        for (int i = 0; i < 80; i++)
        begin
            if (i == 40)
                settle();
            px = make_rgb($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            send_pixel(px, i == 0);
        end
        tx_steady = 1'b0;
    endtask

    // Random phases: new settings, then mostly well-formed frames with random
    // content; some frames lack the frame mark, stop mid-row or carry a stray
    // frame mark in the middle.
    task automatic test_random_frames();
        int       sent;
        int       sel;
        int       width;
        int       eff;
        int       count;
        int       base;
        bit       marked;
        logic     frame_start;
        content_t mode;
        rgb_t     px;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);

            sel = $urandom_range(0, 99);
            if (sel < 4)
                width = 0;
            else if (sel < 8)
                width = $urandom_range(MAX_WIDTH + 1, 2047);
            else if (sel < 10)
                width = MAX_WIDTH;
            else if (sel < 18)
                width = $urandom_range(17, 64);
            else
                width = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_IMAGE_WIDTH, width[WIDTH_W-1:0]);

            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 3) != 0)
            begin
                if (sel < 10)
                    base = 0;
                else if (sel < 20)
                    base = 255;
                else if (sel < 25)
                    base = 1;
                else if (sel < 30)
                    base = 254;
                else
                    base = $urandom_range(0, 255);
                write_reg(CFG_THRESHOLD, {3'($urandom_range(0, 7)), 8'(base)});
            end

            eff = int'(width_setting);
            if (eff < 1)
                eff = 1;
            if (eff > MAX_WIDTH)
                eff = MAX_WIDTH;

            repeat ($urandom_range(1, 3))
            begin
                if (eff > 64)
                    count = $urandom_range(10, 80);
                else
                    count = eff * $urandom_range(1, 6);
                // Broken frame: stop partway, possibly mid-row.
                if ($urandom_range(0, 6) == 0)
                    count = $urandom_range(1, count);
                marked = ($urandom_range(0, 9) != 0);
                mode   = content_t'($urandom_range(0, 3));
                base   = $urandom_range(0, 255);
                for (int i = 0; i < count && sent < RANDOM_PIXELS; i++)
                begin
                    frame_start = (i == 0 && marked) || ($urandom_range(0, 199) == 0);
                    px = make_rgb(pick_sample(mode, base), pick_sample(mode, base),
                                  pick_sample(mode, base));
                    send_pixel(px, frame_start);
                    sent++;
                    // Occasionally hold the sender until the block drains.
                    if ($urandom_range(0, 499) == 0)
                        settle();
                end
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data  = '0;

        error_count       = 0;
        pixels_sent       = 0;
        rows_predicted    = 0;
        results_checked   = 0;
        reg_writes        = 0;
        tx_steady         = 1'b0;
        rx_steady         = 1'b0;
        width_setting     = 11'd256;
        threshold_setting = 8'd128;
        clear_diffusion();

        // Hold reset, then release it on a rising edge.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_row_geometry();
        test_threshold_extremes();
        test_spare_indexes();
        test_widest_row();
        test_sender_pause();
        test_random_frames();

        // Wait for the last results, then let the pipeline run out.
        settle();

        $display("Halftoned %0d pixels in %0d rows, %0d results compared, %0d register writes",
                 pixels_sent, rows_predicted, results_checked, reg_writes);
        $display("Widths 0 to 2047 with mid-row changes, thresholds 0 to 255, frame marks and stalls");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("timeout with %0d results still outstanding", halftone_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rgbht_pkg.sv
rtl/rgbht_front.sv
rtl/rgbht_queue.sv
rtl/rgbht_back.sv
rtl/rgb_error_diffusion_halftone_top.sv
tb/sv/testbench.sv
